@@ design/vkd_pkg.sv @@
// ----------------------------------------------------------------------------
// vkd_pkg
// Shared types, byte constants and key code maps for the VT100 key decoder.
// ----------------------------------------------------------------------------
package vkd_pkg;

  // widths of the payload fields
  localparam int BYTE_W = 8;
  localparam int CODE_W = 7;
  localparam int PARAM_W = 7;
  localparam int DIGITS_W = 2;

  // default sequence length limit for a CSI without final byte
  localparam int MAX_CSI_BYTES_DEF = 12;

  // parser modes
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SS3  = 2'd2,
    MODE_CSI  = 2'd3
  } mode_t;

  // result of one byte step
  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } vkd_res_t;

  // terminal bytes
  localparam logic [BYTE_W-1:0] B_ESC   = 8'd27;
  localparam logic [BYTE_W-1:0] B_SS3   = 8'h4F; // 'O'
  localparam logic [BYTE_W-1:0] B_CSI   = 8'h5B; // '['
  localparam logic [BYTE_W-1:0] B_AT    = 8'h40; // '@'
  localparam logic [BYTE_W-1:0] B_TILDE = 8'h7E; // '~'
  localparam logic [BYTE_W-1:0] B_DEL   = 8'd127;
  localparam logic [BYTE_W-1:0] B_CTLX  = 8'd24;
  localparam logic [BYTE_W-1:0] B_CTLO  = 8'd15;
  localparam logic [BYTE_W-1:0] B_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] B_BS    = 8'd8;
  localparam logic [BYTE_W-1:0] B_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] B_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] B_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] B_ZERO  = 8'h30; // '0'
  localparam logic [BYTE_W-1:0] B_NINE  = 8'h39; // '9'
  localparam logic [BYTE_W-1:0] B_SEMI  = 8'h3B; // ';'
  localparam logic [BYTE_W-1:0] B_A     = 8'h41;
  localparam logic [BYTE_W-1:0] B_B     = 8'h42;
  localparam logic [BYTE_W-1:0] B_C     = 8'h43;
  localparam logic [BYTE_W-1:0] B_D     = 8'h44;
  localparam logic [BYTE_W-1:0] B_F     = 8'h46;
  localparam logic [BYTE_W-1:0] B_H     = 8'h48;
  localparam logic [BYTE_W-1:0] B_Z     = 8'h5A;

  // key codes
  localparam logic [CODE_W-1:0] K_NONE    = 7'd0;
  localparam logic [CODE_W-1:0] K_UP      = 7'd1;
  localparam logic [CODE_W-1:0] K_DOWN    = 7'd2;
  localparam logic [CODE_W-1:0] K_LEFT    = 7'd3;
  localparam logic [CODE_W-1:0] K_RIGHT   = 7'd4;
  localparam logic [CODE_W-1:0] K_PGUP    = 7'd5;
  localparam logic [CODE_W-1:0] K_PGDN    = 7'd6;
  localparam logic [CODE_W-1:0] K_HOME    = 7'd7;
  localparam logic [CODE_W-1:0] K_END     = 7'd8;
  localparam logic [CODE_W-1:0] K_EXIT    = 7'd9;
  localparam logic [CODE_W-1:0] K_BKSP    = 7'd10;
  localparam logic [CODE_W-1:0] K_ENTER   = 7'd11;
  localparam logic [CODE_W-1:0] K_DELETE  = 7'd12;
  localparam logic [CODE_W-1:0] K_SAVE    = 7'd13;
  localparam logic [CODE_W-1:0] K_TAB     = 7'd14;
  localparam logic [CODE_W-1:0] K_BACKTAB = 7'd15;

  // cursor letters shared by SS3 and CSI
  function automatic logic [CODE_W-1:0] map_letter(input logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0] c;
    unique case (b)
      B_A:     c = K_UP;
      B_B:     c = K_DOWN;
      B_D:     c = K_LEFT;
      B_C:     c = K_RIGHT;
      B_H:     c = K_HOME;
      B_F:     c = K_END;
      default: c = K_NONE;
    endcase
    return c;
  endfunction

  // single byte outside a sequence
  function automatic logic [CODE_W-1:0] map_idle(input logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0] c;
    priority if (b == B_CTLX)                  c = K_EXIT;
    else if (b == B_CTLO)                      c = K_SAVE;
    else if (b == B_TAB)                       c = K_TAB;
    else if (b == B_BS)                        c = K_BKSP;
    else if (b == B_DEL)                       c = K_DELETE;
    else if (b == B_CR || b == B_LF)           c = K_ENTER;
    else if (b >= B_SPACE && b < B_DEL)        c = b[CODE_W-1:0];
    else                                       c = K_NONE;
    return c;
  endfunction

  // '~' final byte keyed by the first parameter
  function automatic logic [CODE_W-1:0] map_tilde(input logic [PARAM_W-1:0] p);
    logic [CODE_W-1:0] c;
    unique case (p)
      7'd1, 7'd7: c = K_HOME;
      7'd3:       c = K_DELETE;
      7'd4, 7'd8: c = K_END;
      7'd5:       c = K_PGUP;
      7'd6:       c = K_PGDN;
      default:    c = K_NONE;
    endcase
    return c;
  endfunction

endpackage

@@ design/vkd_parser.sv @@
// ----------------------------------------------------------------------------
// vkd_parser
// Escape sequence state and per-byte key decode, one byte per step.
// ----------------------------------------------------------------------------
module vkd_parser #(
  parameter int MAX_CSI_BYTES = vkd_pkg::MAX_CSI_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [vkd_pkg::BYTE_W-1:0]  key_byte,
  output vkd_pkg::vkd_res_t           res
);
  import vkd_pkg::*;

  localparam int CNT_W = $clog2(MAX_CSI_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CSI_BYTES);

  mode_t               mode_r, mode_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PARAM_W-1:0]  param_r, param_nxt;
  logic [DIGITS_W-1:0] digits_r, digits_nxt;

  logic                is_final;
  logic                is_digit;
  logic [CNT_W-1:0]    cnt_inc;
  logic [PARAM_W-1:0]  param_acc;

  // byte classes inside a CSI
  assign is_final  = (key_byte >= B_AT) && (key_byte <= B_TILDE);
  assign is_digit  = (key_byte >= B_ZERO) && (key_byte <= B_NINE);
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign param_acc = PARAM_W'(param_r * PARAM_W'(10))
                   + PARAM_W'(key_byte[3:0]);

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    param_nxt  = param_r;
    digits_nxt = digits_r;
    unique case (mode_r)
      MODE_IDLE: begin
        if (key_byte == B_ESC) begin
          mode_nxt = MODE_ESC;
        end
      end
      MODE_ESC: begin
        if (key_byte == B_SS3) begin
          mode_nxt = MODE_SS3;
        end else if (key_byte == B_CSI) begin
          mode_nxt   = MODE_CSI;
          cnt_nxt    = '0;
          param_nxt  = '0;
          digits_nxt = '0;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_SS3: begin
        mode_nxt = MODE_IDLE;
      end
      MODE_CSI: begin
        if (is_final || cnt_inc >= CNT_LIMIT) begin
          mode_nxt   = MODE_IDLE;
          cnt_nxt    = '0;
          param_nxt  = '0;
          digits_nxt = '0;
        end else begin
          cnt_nxt = cnt_inc;
          if (is_digit && digits_r < 2'd2) begin
            param_nxt  = param_acc;
            digits_nxt = digits_r + 2'd1;
          end else if (key_byte == B_SEMI) begin
            digits_nxt = 2'd2;
          end
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase
  end

  // result of the current byte
  always_comb begin
    res.hit  = 1'b0;
    res.code = K_NONE;
    unique case (mode_r)
      MODE_IDLE: begin
        res.hit  = (key_byte != B_ESC);
        res.code = map_idle(key_byte);
      end
      MODE_ESC: begin
        res.hit  = (key_byte != B_SS3) && (key_byte != B_CSI);
        res.code = K_NONE;
      end
      MODE_SS3: begin
        res.hit  = 1'b1;
        res.code = map_letter(key_byte);
      end
      MODE_CSI: begin
        if (is_final) begin
          res.hit = 1'b1;
          if (key_byte == B_Z) begin
            res.code = K_BACKTAB;
          end else if (key_byte == B_TILDE) begin
            res.code = map_tilde(param_r);
          end else begin
            res.code = map_letter(key_byte);
          end
        end else begin
          res.hit  = (cnt_inc >= CNT_LIMIT);
          res.code = K_NONE;
        end
      end
      default: begin
        res.hit  = 1'b0;
        res.code = K_NONE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      cnt_r    <= '0;
      param_r  <= '0;
      digits_r <= '0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      cnt_r    <= cnt_nxt;
      param_r  <= param_nxt;
      digits_r <= digits_nxt;
    end
  end

endmodule

@@ design/vt100_key_sequence_decoder.sv @@
// ----------------------------------------------------------------------------
// vt100_key_sequence_decoder
// Decodes VT100/ANSI terminal bytes into editor key codes.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  input   | in_valid, in_ready, in_key_byte     | in
//  result  | out_valid, out_ready, out_key_code  | out
//
//  One byte per cycle unless the result register stalls: a byte is held in
//  the input register, is decoded against the parser state and lands in the
//  result register. out_valid is driven by the result register, so a result
//  transfer follows the input transfer through both registers.
//  Bytes inside an open sequence produce no result transfer.
//  Reset returns the parser to idle and empties both registers.
//  A stalled result register holds the input register, which then drops ready.
// ----------------------------------------------------------------------------
module vt100_key_sequence_decoder #(
  parameter int MAX_CSI_BYTES = vkd_pkg::MAX_CSI_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vkd_pkg::BYTE_W-1:0]  in_key_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vkd_pkg::CODE_W-1:0]  out_key_code
);
  import vkd_pkg::*;

  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_vld_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_free;
  logic              advance;
  vkd_res_t          res;

  // handshake control
  assign out_free = !out_vld_r || out_ready;
  assign advance  = in_vld_r && out_free;
  assign in_ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_key_byte;
    end
  end

  // decode and sequence state
  vkd_parser #(
    .MAX_CSI_BYTES (MAX_CSI_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .key_byte (in_byte_r),
    .res      (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      out_code_r <= res.code;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_key_code = out_code_r;

endmodule

@@ bench/tb_vt100_key_sequence_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vt100_key_sequence_decoder
// Self-checking bench for the VT100 key decoder. A short table of terminal
// bytes hits the single-byte map, the SS3 and CSI paths and the error exits.
// Then about a thousand random bytes follow, mostly well-formed escape
// sequences with random content, mixed with noise and over-long CSI runs.
// Key codes come from a behavioral parser or pinned table rows and are checked
// in order, while in later phases the sender idles, the receiver stalls, or both.
// ----------------------------------------------------------------------------
module tb_vt100_key_sequence_decoder;
  import vkd_pkg::*;

  localparam int CSI_LIMIT = MAX_CSI_BYTES_DEF;
  localparam int RANDOM_BYTES = 1030;
  localparam int DRAIN_CYCLES = 2000;

  // one directed row: byte, and a hand-typed key code where pinned is set
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              pinned;
    logic [CODE_W-1:0] code;
  } key_row_t;

  localparam key_row_t KEY_TABLE [23] = '{
    '{8'h00,   1'b1, K_NONE},
    '{8'hFF,   1'b1, K_NONE},
    '{B_CTLX,  1'b1, K_EXIT},
    '{B_CTLO,  1'b1, K_SAVE},
    '{B_TAB,   1'b1, K_TAB},
    '{B_BS,    1'b1, K_BKSP},
    '{B_DEL,   1'b1, K_DELETE},
    '{B_CR,    1'b1, K_ENTER},
    '{B_LF,    1'b1, K_ENTER},
    '{B_SPACE, 1'b1, 7'd32},
    '{B_TILDE, 1'b1, 7'd126},
    '{B_ESC,   1'b0, K_NONE},
    '{B_SS3,   1'b0, K_NONE},
    '{B_A,     1'b1, K_UP},
    '{B_ESC,   1'b0, K_NONE},
    '{B_CSI,   1'b0, K_NONE},
    '{8'h35,   1'b0, K_NONE},
    '{B_TILDE, 1'b1, K_PGUP},
    '{B_ESC,   1'b0, K_NONE},
    '{B_CSI,   1'b0, K_NONE},
    '{B_Z,     1'b1, K_BACKTAB},
    '{B_ESC,   1'b0, K_NONE},
    '{8'h71,   1'b1, K_NONE}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_key_byte;
  logic              out_valid;
  logic              out_ready;
  logic [CODE_W-1:0] out_key_code;

  vt100_key_sequence_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_key_byte  (in_key_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key_code (out_key_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser mirror
  mode_t               kb_mode;
  logic [3:0]          kb_csi_len;
  logic [PARAM_W-1:0]  kb_param;
  logic [DIGITS_W-1:0] kb_digits;

  logic [CODE_W-1:0] key_code_q [$];
  logic              row_pinned;
  logic [CODE_W-1:0] row_code;
  int                n_bytes_in;
  int                n_codes_checked;
  int                n_errors;
  int                idle_pct;
  int                stall_pct;

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic logic [CODE_W-1:0] cursor_key(input logic [BYTE_W-1:0] b);
    case (b)
      B_A:     return K_UP;
      B_B:     return K_DOWN;
      B_D:     return K_LEFT;
      B_C:     return K_RIGHT;
      B_H:     return K_HOME;
      B_F:     return K_END;
      default: return K_NONE;
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] plain_key(input logic [BYTE_W-1:0] b);
    if (b == B_CTLX) return K_EXIT;
    if (b == B_CTLO) return K_SAVE;
    if (b == B_TAB) return K_TAB;
    if (b == B_BS) return K_BKSP;
    if (b == B_DEL) return K_DELETE;
    if (b == B_CR || b == B_LF) return K_ENTER;
    if (b >= B_SPACE && b < B_DEL) return b[CODE_W-1:0];
    return K_NONE;
  endfunction

  function automatic logic [CODE_W-1:0] tilde_key(input logic [PARAM_W-1:0] p);
    case (p)
      7'd1, 7'd7: return K_HOME;
      7'd3:       return K_DELETE;
      7'd4, 7'd8: return K_END;
      7'd5:       return K_PGUP;
      7'd6:       return K_PGDN;
      default:    return K_NONE;
    endcase
  endfunction

  task automatic clear_parser();
    kb_mode = MODE_IDLE;
    kb_csi_len = '0;
    kb_param = '0;
    kb_digits = '0;
  endtask

  // advance the mirror by one byte; hit tells whether a key code comes out
  task automatic decode_key_byte(input logic [BYTE_W-1:0] b, output logic hit,
                                 output logic [CODE_W-1:0] code);
    hit = 1'b1;
    code = K_NONE;
    case (kb_mode)
      MODE_IDLE: begin
        if (b == B_ESC) begin
          kb_mode = MODE_ESC;
          hit = 1'b0;
        end else begin
          code = plain_key(b);
        end
      end
      MODE_ESC: begin
        if (b == B_SS3) begin
          kb_mode = MODE_SS3;
          hit = 1'b0;
        end else if (b == B_CSI) begin
          clear_parser();
          kb_mode = MODE_CSI;
          hit = 1'b0;
        end else begin
          clear_parser();
        end
      end
      MODE_SS3: begin
        code = cursor_key(b);
        clear_parser();
      end
      default: begin
        if (b >= B_AT && b <= B_TILDE) begin
          if (b == B_Z) code = K_BACKTAB;
          else if (b == B_TILDE) code = tilde_key(kb_param);
          else code = cursor_key(b);
          clear_parser();
        end else begin
          // first two digits of the first parameter, semicolon closes it
          if (b >= B_ZERO && b <= B_NINE) begin
            if (kb_digits < 2) begin
              kb_param = PARAM_W'(kb_param * 10 + (b - B_ZERO));
              kb_digits = kb_digits + 1'b1;
            end
          end else if (b == B_SEMI) begin
            kb_digits = 2'd2;
          end
          kb_csi_len = kb_csi_len + 1'b1;
          // too many bytes without a final one drops the sequence
          if (kb_csi_len >= CSI_LIMIT) clear_parser();
          else hit = 1'b0;
        end
      end
    endcase
  endtask

  // input transfers feed the predictor
  always @(posedge clk) begin : track_input
    logic              hit;
    logic [CODE_W-1:0] code;
    if (rst_n && in_valid && in_ready) begin
      decode_key_byte(in_key_byte, hit, code);
      if (hit) key_code_q.push_back(row_pinned ? row_code : code);
      n_bytes_in++;
    end
  end

  // result transfers against the oldest expected key code
  always @(posedge clk) begin : check_output
    logic [CODE_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (key_code_q.size() == 0) begin
        report_mismatch($sformatf("key code %0d with none expected", out_key_code));
      end else begin
        want = key_code_q.pop_front();
        n_codes_checked++;
        if (out_key_code !== want)
          report_mismatch($sformatf("key code %0d, expected %0d", out_key_code, want));
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_key_byte(input logic [BYTE_W-1:0] b, input logic pinned,
                               input logic [CODE_W-1:0] code);
    int target;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    row_pinned = pinned;
    row_code = code;
    in_valid <= 1'b1;
    in_key_byte <= b;
    target = n_bytes_in + 1;
    do @(negedge clk); while (n_bytes_in < target);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_key_byte(b, 1'b0, K_NONE);
  endtask

  // decimal digits of a parameter, with an occasional leading zero
  task automatic send_number(input int v);
    if ($urandom_range(7) == 0) send_byte(B_ZERO);
    if (v >= 100) send_byte(8'(B_ZERO + v / 100));
    if (v >= 10) send_byte(8'(B_ZERO + (v / 10) % 10));
    send_byte(8'(B_ZERO + v % 10));
  endtask

  function automatic logic [BYTE_W-1:0] pick_letter();
    case ($urandom_range(6))
      0:       return B_A;
      1:       return B_B;
      2:       return B_C;
      3:       return B_D;
      4:       return B_H;
      5:       return B_F;
      default: return B_Z;
    endcase
  endfunction

  // any byte outside the CSI final range
  function automatic logic [BYTE_W-1:0] filler_byte();
    logic [BYTE_W-1:0] r;
    r = 8'($urandom_range(255));
    if (r >= B_AT && r <= B_TILDE) r = r ^ 8'h40;
    return r;
  endfunction

  // one random key: noise, SS3, broken escape, or a CSI sequence
  task automatic send_random_key();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 25) begin
      send_byte(8'($urandom_range(255)));
    end else if (kind < 40) begin
      send_byte(B_ESC);
      send_byte(B_SS3);
      send_byte(($urandom_range(3) != 0) ? pick_letter() : 8'($urandom_range(255)));
    end else if (kind < 48) begin
      send_byte(B_ESC);
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(B_ESC);
      send_byte(B_CSI);
      if ($urandom_range(9) == 0) begin
        // over-long sequence, may or may not hit the byte limit
        n = $urandom_range(CSI_LIMIT + 2, CSI_LIMIT - 2);
        repeat (n) send_byte(filler_byte());
        if ($urandom_range(1) == 0) send_byte(B_TILDE);
      end else begin
        if ($urandom_range(9) != 0)
          send_number(($urandom_range(9) < 7) ? $urandom_range(8, 1) : $urandom_range(999));
        if ($urandom_range(3) == 0) begin
          send_byte(B_SEMI);
          send_number($urandom_range(99));
        end
        if ($urandom_range(4) == 0) send_byte(filler_byte());
        n = $urandom_range(9);
        if (n < 5) send_byte(B_TILDE);
        else if (n < 8) send_byte(pick_letter());
        else send_byte(8'($urandom_range(8'h7E, 8'h40)));
      end
    end
  endtask

  // hold the sender off until every expected key code has arrived or the drain limit is reached
  task automatic wait_for_drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      n++;
    end while (key_code_q.size() != 0 && n < DRAIN_CYCLES);
  endtask

  initial begin : stimulus
    int ph;
    int n_directed;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_key_byte = '0;
    out_ready = 1'b0;
    row_pinned = 1'b0;
    row_code = K_NONE;
    idle_pct = 0;
    stall_pct = 0;
    n_bytes_in = 0;
    n_codes_checked = 0;
    n_errors = 0;
    clear_parser();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (KEY_TABLE[i]) send_key_byte(KEY_TABLE[i].b, KEY_TABLE[i].pinned, KEY_TABLE[i].code);
    n_directed = n_bytes_in;

    // random phases: free flow, sender gaps, receiver stalls, both
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 60 : (ph == 3) ? 32 : 0;
      stall_pct = (ph == 2) ? 60 : (ph == 3) ? 32 : 0;
      wait_for_drain();
      while (n_bytes_in < n_directed + (ph + 1) * RANDOM_BYTES / 4) send_random_key();
    end

    wait_for_drain();
    repeat (8) @(negedge clk);
    if (key_code_q.size() != 0)
      report_mismatch($sformatf("%0d key codes never arrived", key_code_q.size()));

    $display("covered %0d bytes (%0d from the table), %0d key codes checked",
             n_bytes_in, n_directed, n_codes_checked);
    $display("handshake phases: free flow, sender gaps, receiver stalls, both");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
design/vkd_pkg.sv
design/vkd_parser.sv
design/vt100_key_sequence_decoder.sv
bench/tb_vt100_key_sequence_decoder.sv
